@@ src/rbb_pkg.sv @@
// rbb_pkg: shared types, constants and the reciprocal table of the running box blur
// no dependencies; used by every module of the block except rbb_ram

package rbb_pkg;

  localparam int unsigned NumChan    = 4;
  localparam int unsigned ChanBits   = 16;
  localparam int unsigned PixBits    = NumChan * ChanBits;
  localparam int unsigned SumBits    = ChanBits + 6;
  localparam int unsigned RadiusBits = 5;
  localparam int unsigned RadiusCap  = 31;
  localparam int unsigned RecipShift = 24;
  localparam int unsigned RecipBits  = RecipShift + 1;
  localparam int unsigned ProdBits   = SumBits + RecipBits;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [ChanBits-1:0] ChanMax = '1;

  typedef logic [ChanBits-1:0]   chan_t;
  typedef logic [PixBits-1:0]    pixel_t;
  typedef logic [SumBits-1:0]    sum_t;
  typedef logic [RadiusBits-1:0] radius_t;
  typedef logic [RecipBits-1:0]  recip_t;
  typedef logic [ProdBits-1:0]   prod_t;

  typedef struct packed {
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic [15:0] alpha_in;
    logic        line_end_in;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] alpha_out;
    logic        line_end_out;
  } pix_out_t;

  // one sum update: optional add of the new pixel, optional drop of an old one
  typedef struct packed {
    logic   add_en;
    pixel_t add_pix;
    logic   sub_en;
    logic   emit;
    logic   last_out;
    logic   clr;
  } op_t;

  typedef struct packed {
    op_t    op;
    pixel_t sub_pix;
  } qentry_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             empty;
    logic             full;
  } q_status_t;

  typedef struct packed {
    logic flushing;
    logic s1_valid;
  } front_status_t;

  // round(2^24 / (2r + 1))
  function automatic recip_t recip_lut(input radius_t r);
    recip_t v;
    case (r)
      5'd0:    v = 25'd16777216;
      5'd1:    v = 25'd5592405;
      5'd2:    v = 25'd3355443;
      5'd3:    v = 25'd2396745;
      5'd4:    v = 25'd1864135;
      5'd5:    v = 25'd1525201;
      5'd6:    v = 25'd1290555;
      5'd7:    v = 25'd1118481;
      5'd8:    v = 25'd986895;
      5'd9:    v = 25'd883011;
      5'd10:   v = 25'd798915;
      5'd11:   v = 25'd729444;
      5'd12:   v = 25'd671089;
      5'd13:   v = 25'd621378;
      5'd14:   v = 25'd578525;
      5'd15:   v = 25'd541201;
      5'd16:   v = 25'd508400;
      5'd17:   v = 25'd479349;
      5'd18:   v = 25'd453438;
      5'd19:   v = 25'd430185;
      5'd20:   v = 25'd409200;
      5'd21:   v = 25'd390168;
      5'd22:   v = 25'd372827;
      5'd23:   v = 25'd356962;
      5'd24:   v = 25'd342392;
      5'd25:   v = 25'd328965;
      5'd26:   v = 25'd316551;
      5'd27:   v = 25'd305040;
      5'd28:   v = 25'd294337;
      5'd29:   v = 25'd284360;
      5'd30:   v = 25'd275036;
      default: v = 25'd266305;
    endcase
    return v;
  endfunction

endpackage

@@ src/running_box_blur_line_unit.sv @@
// running_box_blur_line_unit: top level of the running box blur over one pixel line
// depends on rbb_pkg, rbb_ram, rbb_queue, rbb_front and rbb_back

// Box blur of one line of premultiplied RGBA pixels, 16-bit channels. Output pixel i
// is the sum of input pixels i-r .. i+r divided by 2r+1, with pixels beyond the line
// ends counting as zero, rounded and clamped to full scale. Output i leaves once
// input i+r has been taken; the pixel marked as line end then releases the remaining
// min(r, line length) outputs, the last of which carries line_end_out. Pixels are
// taken at one per cycle while the queue has room; after a line-end pixel in_stall_o
// stays high until the flush is done, since every flushed output needs its own read
// of the single read port of the history ring. The radius register resets to 1, is
// clamped to RADIUS_MAX and must only be written between lines while the block is
// empty. There is no clearing pass after reset: read data is only used from slots
// already written in the current line.

module running_box_blur_line_unit #(
  parameter int unsigned RADIUS_MAX = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration: radius
  input  logic                 cfg_we_i,
  input  rbb_pkg::radius_t     cfg_wdata_i,
  // pixel input
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rbb_pkg::pix_in_t     in_data_i,
  // blurred pixel output
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rbb_pkg::pix_out_t    out_data_o
);

  // history ring holds a full window at the largest radius
  localparam int unsigned HistDepth = 2 * RADIUS_MAX + 1;
  localparam int unsigned SlotW     = $clog2(HistDepth);
  localparam int unsigned RClamp    = (RADIUS_MAX < rbb_pkg::RadiusCap) ? RADIUS_MAX
                                                                        : rbb_pkg::RadiusCap;
  localparam int unsigned OccW      = rbb_pkg::QCntW + 1;

  rbb_pkg::radius_t        radius_q, eff_radius;

  logic                    ram_we, ram_re;
  logic [SlotW-1:0]        ram_waddr, ram_raddr;
  rbb_pkg::pixel_t         ram_wdata, ram_rdata;

  logic                    q_push, q_pop;
  rbb_pkg::qentry_t        q_entry, q_head;
  rbb_pkg::q_status_t      q_status;
  rbb_pkg::front_status_t  front_status;
  logic [OccW-1:0]         q_occupancy;

  // radius register, reset value 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= rbb_pkg::RadiusBits'(1);
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // radius beyond the ring size is clamped
  assign eff_radius = (radius_q > rbb_pkg::RadiusBits'(RClamp)) ?
                      rbb_pkg::RadiusBits'(RClamp) : radius_q;

  // history ring: written with each taken pixel, read for the pixel leaving the window
  rbb_ram #(
    .Width (rbb_pkg::PixBits),
    .Depth (HistDepth)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // front: takes pixels, sequences the line-end flush, builds sum updates
  rbb_front #(
    .HistDepth (HistDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .eff_radius_i (eff_radius),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .q_count_i    (q_status.count),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .push_o       (q_push),
    .push_entry_o (q_entry),
    .status_o     (front_status)
  );

  // decoupling queue, so an output stall does not reach the ring reads directly
  rbb_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .entry_i  (q_entry),
    .pop_i    (q_pop),
    .head_o   (q_head),
    .status_o (q_status)
  );

  // back: running sums, reciprocal multiply, rounding and output register
  rbb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .eff_radius_i (eff_radius),
    .head_i       (q_head),
    .q_empty_i    (q_status.empty),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  // queued plus in-flight updates
  assign q_occupancy = OccW'(q_status.count) + OccW'(front_status.s1_valid);

  // an update leaving the read stage always finds room in the queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_status.s1_valid |-> !q_status.full)
    else $error("sum update pushed into a full queue");

  // credit scheme never promises more slots than the queue has
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_occupancy <= OccW'(rbb_pkg::QueueDepth))
    else $error("queue credit exceeded");

  // a line end with a non-zero radius must start a flush that holds off new pixels
  a_flush_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.line_end_in && (eff_radius != '0))
    |=> (in_stall_o && front_status.flushing))
    else $error("line end transfer did not start a flush");

  // no pixel is written to the ring while a flush is reading it
  a_no_write_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_status.flushing |-> !ram_we)
    else $error("history write during flush");

endmodule

@@ src/rbb_ram.sv @@
// rbb_ram: generic single-write, single-read memory with registered read data
// read returns the old word when read and write hit the same address

module rbb_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 63
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/rbb_queue.sv @@
// rbb_queue: short fifo of sum updates between the front and back parts
// depends on rbb_pkg for the entry and status types

module rbb_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rbb_pkg::qentry_t   entry_i,
  input  logic               pop_i,
  output rbb_pkg::qentry_t   head_o,
  output rbb_pkg::q_status_t status_o
);

  rbb_pkg::qentry_t               entries_q [rbb_pkg::QueueDepth];
  logic [rbb_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [rbb_pkg::QCntW-1:0]      count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + rbb_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + rbb_pkg::QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + rbb_pkg::QCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - rbb_pkg::QCntW'(1);
      end
    end
  end

  assign head_o         = entries_q[rd_ptr_q];
  assign status_o.count = count_q;
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == rbb_pkg::QCntW'(rbb_pkg::QueueDepth));

endmodule

@@ src/rbb_front.sv @@
// rbb_front: accepts pixels, writes the history ring and turns each pixel and each
// line-end flush step into a sum update for the queue; depends on rbb_pkg

module rbb_front #(
  parameter int unsigned HistDepth = 63
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rbb_pkg::radius_t               eff_radius_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rbb_pkg::pix_in_t               in_data_i,
  input  logic [rbb_pkg::QCntW-1:0]      q_count_i,
  output logic                           ram_we_o,
  output logic [$clog2(HistDepth)-1:0]   ram_waddr_o,
  output rbb_pkg::pixel_t                ram_wdata_o,
  output logic                           ram_re_o,
  output logic [$clog2(HistDepth)-1:0]   ram_raddr_o,
  input  rbb_pkg::pixel_t                ram_rdata_i,
  output logic                           push_o,
  output rbb_pkg::qentry_t               push_entry_o,
  output rbb_pkg::front_status_t         status_o
);

  localparam int unsigned SlotW = $clog2(HistDepth);
  localparam int unsigned PosW  = $clog2(HistDepth + 1);
  localparam int unsigned ExtW  = PosW + 1;
  localparam int unsigned OccW  = rbb_pkg::QCntW + 1;

  typedef enum logic [1:0] {
    FrStream = 2'b01,
    FrFlush  = 2'b10
  } front_state_e;

  front_state_e           state_q, state_d;
  logic [PosW-1:0]        lp_q, lp_d;
  logic [SlotW-1:0]       ring_q, ring_d;
  logic [PosW-1:0]        off_q, off_d;
  logic [PosW-1:0]        left_q, left_d;
  logic                   s1_valid_q;
  rbb_pkg::op_t           s1_op_q;

  logic [PosW-1:0]        r_pos, w_pos, lp_new, pending, first_off;
  logic                   credit_ok, accept, flush_go, issue, r_zero, in_last;
  rbb_pkg::op_t           op_d;
  logic [SlotW-1:0]       raddr;
  rbb_pkg::pixel_t        in_pix;

  // slot of the pixel written off places before the current ring slot
  function automatic logic [SlotW-1:0] slot_back(input logic [SlotW-1:0] ring,
                                                 input logic [PosW-1:0]  off);
    logic [ExtW-1:0] ring_ext, off_ext, res;
    ring_ext = ExtW'(ring);
    off_ext  = ExtW'(off);
    if (off_ext <= ring_ext) begin
      res = ring_ext - off_ext;
    end else begin
      res = ring_ext + ExtW'(HistDepth) - off_ext;
    end
    return res[SlotW-1:0];
  endfunction

  assign in_pix  = {in_data_i.alpha_in, in_data_i.blue_in,
                    in_data_i.green_in, in_data_i.red_in};
  assign in_last = in_data_i.line_end_in;

  assign r_pos  = PosW'(eff_radius_i);
  assign w_pos  = (r_pos << 1) | PosW'(1);
  assign r_zero = (eff_radius_i == '0);
  assign lp_new = (lp_q < PosW'(HistDepth)) ? lp_q + PosW'(1) : lp_q;
  assign pending   = (lp_new < r_pos) ? lp_new : r_pos;
  assign first_off = pending + r_pos;

  // one queue slot is reserved for the update sitting in the read stage
  assign credit_ok  = (OccW'(q_count_i) + OccW'(s1_valid_q)) < OccW'(rbb_pkg::QueueDepth);
  assign in_stall_o = (state_q != FrStream) || !credit_ok;
  assign accept     = in_valid_i && !in_stall_o;
  assign flush_go   = (state_q == FrFlush) && credit_ok;
  assign issue      = accept || flush_go;

  always_comb begin
    op_d = '0;
    if (state_q == FrFlush) begin
      op_d.sub_en   = (off_q < lp_q);
      op_d.emit     = 1'b1;
      op_d.last_out = (left_q == PosW'(1));
      op_d.clr      = (left_q == PosW'(1));
      raddr         = slot_back(ring_q, off_q);
    end else begin
      op_d.add_en   = 1'b1;
      op_d.add_pix  = in_pix;
      op_d.sub_en   = (lp_q >= w_pos);
      op_d.emit     = (lp_new > r_pos);
      op_d.last_out = in_last && r_zero;
      op_d.clr      = in_last && r_zero;
      raddr         = slot_back(ring_q, w_pos);
    end
  end

  always_comb begin
    state_d = state_q;
    lp_d    = lp_q;
    ring_d  = ring_q;
    off_d   = off_q;
    left_d  = left_q;
    case (state_q)
      FrStream: begin
        if (accept) begin
          if (in_last && r_zero) begin
            lp_d   = '0;
            ring_d = '0;
          end else if (in_last) begin
            lp_d    = lp_new;
            off_d   = first_off;
            left_d  = pending;
            state_d = FrFlush;
          end else begin
            lp_d   = lp_new;
            ring_d = (ring_q == SlotW'(HistDepth - 1)) ? '0 : ring_q + SlotW'(1);
          end
        end
      end
      FrFlush: begin
        if (flush_go) begin
          off_d  = off_q - PosW'(1);
          left_d = left_q - PosW'(1);
          if (left_q == PosW'(1)) begin
            state_d = FrStream;
            lp_d    = '0;
            ring_d  = '0;
          end
        end
      end
      default: begin
        state_d = FrStream;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FrStream;
      lp_q       <= '0;
      ring_q     <= '0;
      off_q      <= '0;
      left_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      lp_q       <= lp_d;
      ring_q     <= ring_d;
      off_q      <= off_d;
      left_q     <= left_d;
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_op_q <= op_d;
    end
  end

  assign ram_we_o    = accept;
  assign ram_waddr_o = ring_q;
  assign ram_wdata_o = in_pix;
  assign ram_re_o    = issue;
  assign ram_raddr_o = raddr;

  assign push_o               = s1_valid_q;
  assign push_entry_o.op      = s1_op_q;
  assign push_entry_o.sub_pix = ram_rdata_i;

  assign status_o.flushing = (state_q == FrFlush);
  assign status_o.s1_valid = s1_valid_q;

endmodule

@@ src/rbb_back.sv @@
// rbb_back: applies queued sum updates, scales emitted sums by the window reciprocal
// and holds the result in the output register; depends on rbb_pkg

module rbb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rbb_pkg::radius_t    eff_radius_i,
  input  rbb_pkg::qentry_t    head_i,
  input  logic                q_empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rbb_pkg::pix_out_t   out_data_o
);

  localparam int unsigned RndW = rbb_pkg::ProdBits + 1;
  localparam int unsigned ShW  = RndW - rbb_pkg::RecipShift;

  rbb_pkg::sum_t     sums_q    [rbb_pkg::NumChan];
  rbb_pkg::sum_t     sum_new   [rbb_pkg::NumChan];
  logic              e_valid_q, e_last_q;
  rbb_pkg::sum_t     e_sums_q  [rbb_pkg::NumChan];
  rbb_pkg::recip_t   e_recip_q;
  logic              m_valid_q, m_last_q;
  rbb_pkg::prod_t    m_prod_q  [rbb_pkg::NumChan];
  rbb_pkg::chan_t    chan_res  [rbb_pkg::NumChan];
  logic              out_valid_q;
  rbb_pkg::pix_out_t out_q;
  logic              adv;

  // the whole pipe moves together and holds while the output is stalled
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && !q_empty_i;

  always_comb begin
    for (int ch = 0; ch < rbb_pkg::NumChan; ch++) begin
      rbb_pkg::sum_t add_v, sub_v;
      add_v = head_i.op.add_en ?
              rbb_pkg::SumBits'(head_i.op.add_pix[ch*rbb_pkg::ChanBits +: rbb_pkg::ChanBits])
              : '0;
      sub_v = head_i.op.sub_en ?
              rbb_pkg::SumBits'(head_i.sub_pix[ch*rbb_pkg::ChanBits +: rbb_pkg::ChanBits])
              : '0;
      sum_new[ch] = sums_q[ch] - sub_v + add_v;
    end
  end

  always_comb begin
    for (int ch = 0; ch < rbb_pkg::NumChan; ch++) begin
      logic [RndW-1:0] rnd;
      logic [ShW-1:0]  sh;
      rnd = RndW'(m_prod_q[ch]) + RndW'(2 ** (rbb_pkg::RecipShift - 1));
      sh  = rnd[RndW-1:rbb_pkg::RecipShift];
      chan_res[ch] = (sh > ShW'(rbb_pkg::ChanMax)) ? rbb_pkg::ChanMax
                                                   : sh[rbb_pkg::ChanBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int ch = 0; ch < rbb_pkg::NumChan; ch++) begin
        sums_q[ch] <= '0;
      end
      e_valid_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      if (pop_o) begin
        for (int ch = 0; ch < rbb_pkg::NumChan; ch++) begin
          sums_q[ch] <= head_i.op.clr ? '0 : sum_new[ch];
        end
      end
      e_valid_q   <= pop_o && head_i.op.emit;
      m_valid_q   <= e_valid_q;
      out_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int ch = 0; ch < rbb_pkg::NumChan; ch++) begin
        e_sums_q[ch] <= sum_new[ch];
        m_prod_q[ch] <= rbb_pkg::ProdBits'(e_sums_q[ch]) * rbb_pkg::ProdBits'(e_recip_q);
      end
      e_last_q  <= head_i.op.last_out;
      e_recip_q <= rbb_pkg::recip_lut(eff_radius_i);
      m_last_q  <= e_last_q;
      out_q.red_out      <= chan_res[0];
      out_q.green_out    <= chan_res[1];
      out_q.blue_out     <= chan_res[2];
      out_q.alpha_out    <= chan_res[3];
      out_q.line_end_out <= m_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
